@@ src/mrcc_pkg.sv @@
// shared types, constants and codes for the multi-frame reassembly block
package mrcc_pkg;

    // message store size in bytes and the largest payload per frame
    localparam int MSG_BYTES   = 32;
    localparam int PAYLOAD_MAX = 7;

    // store address width and a width that can also hold MSG_BYTES itself
    localparam int ADDR_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int IDX_W  = $clog2(MSG_BYTES + 1);

    // frame field widths
    localparam int NODE_W    = 7;
    localparam int LEN_W     = 3;
    localparam int PAYLOAD_W = 56;
    localparam int CRC_W     = 16;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // node id after reset and the crc seed
    localparam logic [NODE_W-1:0] NODE_ID_RESET = 7'h16;
    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;

    // per-frame result status
    typedef enum logic [2:0] {
        ST_IGNORED      = 3'd0,
        ST_START        = 3'd1,
        ST_MIDDLE       = 3'd2,
        ST_OUT_OF_PLACE = 3'd3,
        ST_CRC_OK       = 3'd4,
        ST_CRC_BAD      = 3'd5,
        ST_SHORT_START  = 3'd6
    } status_t;

    // one classified frame, as handed from front to back
    typedef struct packed {
        logic                 is_end;
        status_t              status;
        logic                 ovf;
        logic [IDX_W-1:0]     base;
        logic [LEN_W-1:0]     count;
        logic [PAYLOAD_W-1:0] bytes;
        logic [CRC_W-1:0]     crc;
    } mrcc_cmd_t;

    // queue fill flags
    typedef struct packed {
        logic full;
        logic empty;
    } mrcc_qstat_t;

endpackage

@@ src/mrcc_front.sv @@
// front end: node filter, frame classification, toggle and write position tracking
module mrcc_front import mrcc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [NODE_W-1:0]      cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [71:0]            s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   s_tlast,
    input  mrcc_qstat_t            q_stat,
    output logic                   q_push,
    output mrcc_cmd_t              q_cmd
);

    logic [NODE_W-1:0] node_id_reg;
    logic              toggle_seen_reg, toggle_seen_next;
    logic [CRC_W-1:0]  received_crc_reg, received_crc_next;
    logic [IDX_W-1:0]  write_index_reg, write_index_next;

    logic [NODE_W-1:0]    src_node;
    logic                 sot, eot, tog;
    logic [LEN_W-1:0]     len_in, len_c, from, avail, wcount;
    logic [PAYLOAD_W-1:0] payload;
    logic [IDX_W-1:0]     base, room;
    logic                 ovf, append, accept;

    // field unpack
    assign src_node = s_tdata[6:0];
    assign len_in   = s_tdata[9:7];
    assign payload  = s_tdata[65:10];
    assign sot      = s_tuser[0];
    assign tog      = s_tuser[1];
    assign eot      = s_tlast;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // byte count that fits into the store
    always_comb begin
        len_c  = (8'(len_in) > 8'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : len_in;
        from   = sot ? LEN_W'(2) : '0;
        avail  = (len_c > from) ? LEN_W'(len_c - from) : '0;
        base   = sot ? '0 : write_index_reg;
        room   = IDX_W'(MSG_BYTES) - base;
        ovf    = 8'(avail) > 8'(room);
        wcount = ovf ? LEN_W'(room) : avail;
    end

    // classification and next state
    always_comb begin
        toggle_seen_next  = toggle_seen_reg;
        received_crc_next = received_crc_reg;
        write_index_next  = write_index_reg;
        append            = 1'b0;
        q_cmd.is_end      = 1'b0;
        q_cmd.status      = ST_IGNORED;
        q_cmd.bytes       = sot ? (payload >> 16) : payload;
        q_cmd.crc         = received_crc_reg;
        q_cmd.base        = base;
        if (src_node != node_id_reg) begin
            q_cmd.status = ST_IGNORED;
        end else if (sot) begin
            if (len_c < LEN_W'(2)) begin
                q_cmd.status = ST_SHORT_START;
            end else begin
                q_cmd.status      = ST_START;
                toggle_seen_next  = 1'b0;
                received_crc_next = payload[15:0];
                append            = 1'b1;
            end
        end else if (eot) begin
            q_cmd.is_end = 1'b1;
            q_cmd.status = ST_CRC_BAD;
            append       = 1'b1;
        end else if (toggle_seen_reg != tog) begin
            q_cmd.status     = ST_MIDDLE;
            toggle_seen_next = tog;
            append           = 1'b1;
        end else begin
            q_cmd.status     = ST_OUT_OF_PLACE;
            toggle_seen_next = 1'b0;
        end
        q_cmd.ovf   = append && ovf;
        q_cmd.count = append ? wcount : '0;
        if (append) begin
            write_index_next = base + IDX_W'(wcount);
        end
    end

    // state registers and node id register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg      <= NODE_ID_RESET;
            toggle_seen_reg  <= 1'b0;
            received_crc_reg <= '0;
            write_index_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                node_id_reg <= cfg_wr_data;
            end
            if (accept) begin
                toggle_seen_reg  <= toggle_seen_next;
                received_crc_reg <= received_crc_next;
                write_index_reg  <= write_index_next;
            end
        end
    end

endmodule

@@ src/mrcc_queue.sv @@
// short command queue between front end and back end
module mrcc_queue import mrcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  mrcc_cmd_t   push_cmd,
    input  logic        pop,
    output mrcc_cmd_t   head_cmd,
    output mrcc_qstat_t stat
);

    mrcc_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    fill_reg;

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/mrcc_back.sv @@
// back end: message store, crc sweep and result streaming
module mrcc_back import mrcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  mrcc_cmd_t   head_cmd,
    input  mrcc_qstat_t q_stat,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CRC,
        S_EMIT,
        S_RD,
        S_OUT
    } state_t;

    // one byte through the crc-16-ccitt shift register, msb first
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    state_t            state_reg;
    mrcc_cmd_t         cmd_reg;
    logic [LEN_W-1:0]  k_reg;
    status_t           st_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] idx_reg;

    logic              m_tvalid_reg, m_tlast_reg, m_tuser_reg, m_ovf_reg;
    status_t           m_status_reg;
    logic [7:0]        m_data_reg;
    logic [5:0]        m_idx_reg;

    logic [7:0]        store_mem [MSG_BYTES];
    logic [MSG_BYTES-1:0] vld_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_ok_reg;

    logic              mem_we, mem_re, out_free, out_load;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, rd_byte;
    logic [CRC_W-1:0]  crc_new;

    // store access control
    always_comb begin
        mem_we    = (state_reg == S_WRITE) && (k_reg < cmd_reg.count);
        mem_waddr = ADDR_W'(8'(cmd_reg.base) + 8'(k_reg));
        mem_wdata = cmd_reg.bytes[8*k_reg +: 8];
        mem_re    = ((state_reg == S_CRC) && (cnt_reg < IDX_W'(MSG_BYTES)))
                    || (state_reg == S_RD);
        mem_raddr = (state_reg == S_CRC) ? ADDR_W'(cnt_reg) : idx_reg;
        rd_byte   = rd_ok_reg ? rd_data_reg : 8'h00;
        crc_new   = crc_step(crc_reg, rd_byte);
        out_free  = !m_tvalid_reg || m_tready;
        out_load  = ((state_reg == S_EMIT) || (state_reg == S_OUT)) && out_free;
        q_pop     = (state_reg == S_IDLE) && !q_stat.empty;
    end

    // message store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    // written-entry flags, unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                rd_ok_reg <= vld_reg[mem_raddr];
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!q_stat.empty) begin
                        cmd_reg   <= head_cmd;
                        st_reg    <= head_cmd.status;
                        k_reg     <= '0;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (k_reg < cmd_reg.count) begin
                        k_reg <= k_reg + 1'b1;
                    end else if (cmd_reg.is_end) begin
                        crc_reg   <= CRC_INIT;
                        cnt_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_CRC;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_CRC: begin
                    if (cnt_reg < IDX_W'(MSG_BYTES)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    pend_reg <= (cnt_reg < IDX_W'(MSG_BYTES));
                    if (pend_reg) begin
                        crc_reg <= crc_new;
                    end
                    if ((cnt_reg == IDX_W'(MSG_BYTES)) && !pend_reg) begin
                        st_reg    <= (crc_reg == cmd_reg.crc) ? ST_CRC_OK : ST_CRC_BAD;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tuser_reg  <= 1'b0;
                        m_status_reg <= st_reg;
                        m_ovf_reg    <= cmd_reg.ovf;
                        m_data_reg   <= 8'h00;
                        m_idx_reg    <= '0;
                        m_tlast_reg  <= (st_reg != ST_CRC_OK);
                        idx_reg      <= '0;
                        state_reg    <= (st_reg == ST_CRC_OK) ? S_RD : S_IDLE;
                    end
                end
                S_RD: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tuser_reg  <= 1'b1;
                        m_status_reg <= st_reg;
                        m_ovf_reg    <= cmd_reg.ovf;
                        m_data_reg   <= rd_byte;
                        m_idx_reg    <= 6'(idx_reg);
                        m_tlast_reg  <= (idx_reg == ADDR_W'(MSG_BYTES - 1));
                        if (idx_reg == ADDR_W'(MSG_BYTES - 1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign m_tvalid   = m_tvalid_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tdata    = {6'h00, m_idx_reg, m_data_reg, m_ovf_reg, m_status_reg};

endmodule

@@ src/multiframe_reassembly_crc_check.sv @@
// top level of the multi-frame reassembly block with crc-16-ccitt check
//
//  channel  direction  data                                        side band
//  s_       in         tdata: src_node, payload_len, payload       tuser: sot, toggle; tlast: eot
//  m_       out        tdata: status, overflow, data_byte, index   tuser: is_message_byte; tlast
//  cfg_     in         wr_data: battery_node_id                    wr_en
//
//  a frame without an end flag gets its status item once its payload bytes are written into
//  the store; an end frame adds a crc sweep over all MSG_BYTES store entries through the single
//  store read port, and on a match each message byte streamed out takes its own store read
//  the front end takes new frames while the two-entry command queue has room
//  a stalled result channel holds the back end; the front end keeps filling the queue
//  reset clears the node id to its default, toggle, crc, write position and store flags
module multiframe_reassembly_crc_check import mrcc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [NODE_W-1:0] cfg_wr_data,   // battery_node_id
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [71:0]       s_tdata,       // src_node[6:0], payload_len[9:7], payload[65:10]
    input  logic [1:0]        s_tuser,       // start_of_transfer[0], toggle[1]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,       // status[2:0], overflow[3], data_byte[11:4],
                                             // byte_index[17:12]
    output logic [0:0]        m_tuser,       // is_message_byte[0]
    output logic              m_tlast
);

    mrcc_qstat_t q_stat;
    mrcc_cmd_t   push_cmd, head_cmd;
    logic        q_push, q_pop;

    // classification
    mrcc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // command queue
    mrcc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // store, crc and streaming
    mrcc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // queue never takes a command while full
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    // message bytes only follow a good crc
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[2:0] == ST_CRC_OK))
        else $error("message byte without crc_ok status");

    // a status item is last unless message bytes follow
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast == (m_tdata[2:0] != ST_CRC_OK)))
        else $error("status item last flag wrong");

    // streamed index stays inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[17:12] < 6'(MSG_BYTES)))
        else $error("message byte index beyond store");

endmodule

@@ bench/multiframe_reassembly_crc_check_tb.sv @@
// self-checking bench for the multi-frame reassembly block with crc-16-ccitt check
module multiframe_reassembly_crc_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrcc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 22;

    // one bus frame as offered on the input channel
    typedef struct packed {
        logic [NODE_W-1:0]    src;
        logic                 sot;
        logic                 eot;
        logic                 tog;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
    } frame_t;

    // one result item
    typedef struct packed {
        logic        is_byte;
        status_t     status;
        logic        ovf;
        logic [7:0]  data;
        logic [5:0]  idx;
        logic        last;
    } result_t;

    // directed stimulus row, with a status typed in where it is obvious
    typedef struct {
        frame_t  frame;
        bit      typed;
        status_t status;
    } stim_row_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [NODE_W-1:0] cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [71:0]       s_tdata     = '0;
    logic [1:0]        s_tuser     = '0;
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [23:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              m_tlast;

    multiframe_reassembly_crc_check dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // clock, 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // reassembly state as the block should hold it
    logic [NODE_W-1:0]        node_id     = NODE_ID_RESET;
    logic                     toggle_seen = 1'b0;
    logic [CRC_W-1:0]         crc_latched = '0;
    int                       write_pos   = 0;
    logic [MSG_BYTES*8-1:0]   msg_image   = '0;

    result_t   awaited_results[$];
    stim_row_t directed_rows[$];
    int        mismatches    = 0;
    int        node_items    = 0;
    int        sender_gap_pct = 0;
    int        rx_stall_pct  = 0;
    logic      hold_req      = 1'b0;
    logic      hold_taken    = 1'b0;
    int        hold_left     = 0;
    int        stuck_cycles  = 0;

    // crc-16-ccitt, seed 0xffff, msb first, over the whole store image
    function automatic logic [CRC_W-1:0] crc16_ccitt(input logic [MSG_BYTES*8-1:0] img);
        logic [CRC_W-1:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < MSG_BYTES; i++) begin
            crc = crc ^ {img[8*i +: 8], 8'h00};
            for (int k = 0; k < 8; k++) begin
                if (crc[15]) begin
                    crc = {crc[14:0], 1'b0} ^ CRC_POLY;
                end else begin
                    crc = {crc[14:0], 1'b0};
                end
            end
        end
        return crc;
    endfunction

    // write payload bytes [from, len) into a store image; true when any were dropped
    function automatic bit append_payload(inout logic [MSG_BYTES*8-1:0] img, inout int pos,
                                          input logic [PAYLOAD_W-1:0] p,
                                          input int from, input int len);
        bit dropped;
        dropped = 1'b0;
        for (int i = from; i < len; i++) begin
            if (pos < MSG_BYTES) begin
                img[8*pos +: 8] = p[8*i +: 8];
                pos++;
            end else begin
                dropped = 1'b1;
            end
        end
        return dropped;
    endfunction

    // classify one accepted frame, update the state and queue its results
    function automatic void reassemble_frame(input frame_t f);
        result_t r;
        status_t st;
        logic    ovf;
        r   = '0;
        ovf = 1'b0;
        if (f.src != node_id) begin
            r.status = ST_IGNORED;
            r.last   = 1'b1;
            awaited_results.push_back(r);
            return;
        end
        if (f.sot) begin
            if (f.len < 2) begin
                st = ST_SHORT_START;
            end else begin
                st          = ST_START;
                toggle_seen = 1'b0;
                crc_latched = f.payload[15:0];
                write_pos   = 0;
                ovf = append_payload(msg_image, write_pos, f.payload, 2, int'(f.len));
            end
        end else if (f.eot) begin
            ovf = append_payload(msg_image, write_pos, f.payload, 0, int'(f.len));
            st  = (crc16_ccitt(msg_image) == crc_latched) ? ST_CRC_OK : ST_CRC_BAD;
        end else if (toggle_seen != f.tog) begin
            st          = ST_MIDDLE;
            toggle_seen = f.tog;
            ovf = append_payload(msg_image, write_pos, f.payload, 0, int'(f.len));
        end else begin
            st          = ST_OUT_OF_PLACE;
            toggle_seen = 1'b0;
        end
        r.status = st;
        r.ovf    = ovf;
        r.last   = (st != ST_CRC_OK);
        awaited_results.push_back(r);
        // a good crc streams the whole store out
        if (st == ST_CRC_OK) begin
            for (int i = 0; i < MSG_BYTES; i++) begin
                r.is_byte = 1'b1;
                r.data    = msg_image[8*i +: 8];
                r.idx     = i[5:0];
                r.last    = (i == MSG_BYTES - 1);
                awaited_results.push_back(r);
            end
        end
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.src     = NODE_W'($urandom_range(0, 127));
        f.sot     = 1'($urandom_range(0, 1));
        f.eot     = 1'($urandom_range(0, 1));
        f.tog     = 1'($urandom_range(0, 1));
        f.len     = LEN_W'($urandom_range(0, 7));
        f.payload = PAYLOAD_W'({$urandom, $urandom});
        return f;
    endfunction

    function automatic void add_row(input logic [NODE_W-1:0] src, input bit sot, input bit eot,
                                    input bit tog, input int len,
                                    input logic [PAYLOAD_W-1:0] payload,
                                    input bit typed, input status_t status);
        stim_row_t row;
        row.frame  = '{src: src, sot: sot, eot: eot, tog: tog, len: LEN_W'(len),
                       payload: payload};
        row.typed  = typed;
        row.status = status;
        directed_rows.push_back(row);
    endfunction

    // offer one item, wait for the handshake, then predict its results
    task automatic send_frame(input frame_t f, input bit typed = 1'b0,
                              input status_t typed_status = ST_IGNORED);
        result_t r;
        int      depth;
        while (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, f.payload, f.len, f.src};
        s_tuser  <= {f.tog, f.sot};
        s_tlast  <= f.eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (f.src == node_id) node_items++;
        depth = awaited_results.size();
        reassemble_frame(f);
        // a typed row replaces the predicted status item
        if (typed) begin
            while (awaited_results.size() > depth) void'(awaited_results.pop_back());
            r        = '0;
            r.status = typed_status;
            r.last   = 1'b1;
            awaited_results.push_back(r);
        end
    endtask

    // a well-formed transfer with random content; the crc may be spoilt on purpose
    task automatic run_transfer(input bit corrupt);
        frame_t                 plan[$];
        frame_t                 head;
        frame_t                 f;
        logic [MSG_BYTES*8-1:0] img;
        logic [CRC_W-1:0]       crc;
        int                     pos;
        bit                     tg;
        bit                     dropped;
        img  = msg_image;
        pos  = 0;
        tg   = 1'b0;
        head = random_frame();
        head.src = node_id;
        head.sot = 1'b1;
        head.eot = 1'b0;
        head.len = LEN_W'($urandom_range(2, 7));
        dropped = append_payload(img, pos, head.payload, 2, int'(head.len));
        repeat ($urandom_range(0, 5)) begin
            f     = random_frame();
            f.src = node_id;
            f.sot = 1'b0;
            f.eot = 1'b0;
            tg    = !tg;
            f.tog = tg;
            f.len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 7)) : LEN_W'(7);
            dropped = append_payload(img, pos, f.payload, 0, int'(f.len));
            plan.push_back(f);
        end
        f     = random_frame();
        f.src = node_id;
        f.sot = 1'b0;
        f.eot = 1'b1;
        dropped = append_payload(img, pos, f.payload, 0, int'(f.len));
        plan.push_back(f);
        // crc covers the stale tail of the store as well
        crc = crc16_ccitt(img);
        if (corrupt) crc = crc ^ CRC_W'($urandom_range(1, 16'hFFFF));
        head.payload[15:0] = crc;
        plan.push_front(head);
        // now and then a frame from another node slips in between
        if ($urandom_range(0, 3) == 0) begin
            f     = random_frame();
            f.src = node_id ^ NODE_W'($urandom_range(1, 127));
            plan.insert($urandom_range(0, plan.size() - 1), f);
        end
        foreach (plan[i]) send_frame(plan[i]);
    endtask

    // stop offering and let every awaited result come out
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= !(rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // compare each result item with the oldest awaited one
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.is_byte = m_tuser[0];
            got.status  = status_t'(m_tdata[2:0]);
            got.ovf     = m_tdata[3];
            got.data    = m_tdata[11:4];
            got.idx     = m_tdata[17:12];
            got.last    = m_tlast;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result byte=%0b status=%0d ovf=%0b",
                         $time, got.is_byte, got.status, got.ovf,
                         " data=%02h idx=%0d last=%0b", got.data, got.idx, got.last);
            end else begin
                want = awaited_results.pop_front();
                if (got.is_byte !== want.is_byte || got.status !== want.status ||
                    got.ovf !== want.ovf || got.data !== want.data ||
                    got.idx !== want.idx || got.last !== want.last) begin
                    mismatches++;
                    $display("%0t: mismatch expected byte=%0b status=%0d ovf=%0b",
                             $time, want.is_byte, want.status, want.ovf,
                             " data=%02h idx=%0d last=%0b", want.data, want.idx,
                             want.last);
                    $display("%0t:          actual   byte=%0b status=%0d ovf=%0b",
                             $time, got.is_byte, got.status, got.ovf,
                             " data=%02h idx=%0d last=%0b", got.data, got.idx, got.last);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STALL_LIMIT) begin
            $display("multiframe_reassembly_crc_check_tb: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // main sequence
    initial begin
        frame_t            f;
        logic [NODE_W-1:0] next_node;
        int                goal;
        int                pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames against the reset node id
        add_row(7'h17,         1, 0, 0, 7, '1, 1, ST_IGNORED);      // foreign node
        add_row(NODE_ID_RESET, 1, 0, 0, 0, '1, 1, ST_SHORT_START);  // start with no bytes
        add_row(NODE_ID_RESET, 1, 1, 1, 1, '1, 1, ST_SHORT_START);  // one byte, both flags
        add_row(NODE_ID_RESET, 0, 0, 0, 7, '1, 1, ST_OUT_OF_PLACE); // toggle as after reset
        add_row(NODE_ID_RESET, 0, 0, 1, 7, '1, 1, ST_MIDDLE);
        add_row(NODE_ID_RESET, 0, 1, 0, 7, '0, 0, ST_IGNORED);      // end without a start
        add_row(NODE_ID_RESET, 1, 0, 0, 7, '0, 1, ST_START);
        add_row(NODE_ID_RESET, 0, 0, 1, 7, '1, 1, ST_MIDDLE);
        add_row(NODE_ID_RESET, 0, 0, 1, 3, '0, 1, ST_OUT_OF_PLACE); // repeated toggle
        add_row(NODE_ID_RESET, 0, 0, 1, 7, '1, 1, ST_MIDDLE);
        add_row(NODE_ID_RESET, 0, 0, 0, 7, 56'h5A_A5_3C_C3_0F_F0_81, 1, ST_MIDDLE);
        add_row(NODE_ID_RESET, 0, 0, 1, 7, 56'h01_02_04_08_10_20_40, 0, ST_IGNORED); // store fills
        add_row(NODE_ID_RESET, 0, 1, 1, 7, '1, 0, ST_IGNORED);      // end, all bytes dropped
        add_row(NODE_ID_RESET, 0, 0, 0, 0, '0, 1, ST_MIDDLE);       // end left toggle alone
        add_row(NODE_ID_RESET, 1, 1, 0, 2, 56'hBEEF, 1, ST_START);  // start and end together
        add_row(NODE_ID_RESET, 0, 1, 0, 0, '0, 0, ST_IGNORED);      // crc over stale bytes
        add_row(7'h00,         0, 0, 0, 0, '0, 1, ST_IGNORED);
        add_row(7'h7F,         1, 1, 1, 7, '1, 1, ST_IGNORED);
        foreach (directed_rows[i]) begin
            send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].status);
        end
        run_transfer(1'b0);
        run_transfer(1'b1);

        // random phases, each setting a node id and an idling pattern
        for (int phase = 0; phase < 5; phase++) begin
            drain_results(20);
            case (phase)
                0:       next_node = 7'h7F;
                1:       next_node = 7'h00;
                3:       next_node = NODE_ID_RESET;
                default: next_node = NODE_W'($urandom_range(0, 127));
            endcase
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= next_node;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            node_id = next_node;

            case (phase)
                1:       begin sender_gap_pct = 49; rx_stall_pct = 0;  end
                2:       begin sender_gap_pct = 0;  rx_stall_pct = 49; end
                3:       begin sender_gap_pct = 16; rx_stall_pct = 16; end
                default: begin sender_gap_pct = 0;  rx_stall_pct = 0;  end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (phase == 0) hold_req <= 1'b1;

            goal = node_items + PHASE_ITEMS;
            while (node_items < goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    run_transfer($urandom_range(0, 4) == 0);
                end else if (pick < 85) begin
                    // broken transfer: a start then stray frames
                    f     = random_frame();
                    f.src = node_id;
                    f.sot = 1'b1;
                    f.eot = 1'b0;
                    send_frame(f);
                    repeat ($urandom_range(1, 4)) begin
                        f     = random_frame();
                        f.src = node_id;
                        f.sot = ($urandom_range(0, 7) == 0);
                        f.eot = ($urandom_range(0, 3) == 0);
                        send_frame(f);
                    end
                end else begin
                    f = random_frame();
                    if ($urandom_range(0, 1) == 1) f.src = node_id;
                    send_frame(f);
                end
            end
        end

        drain_results(150);
        if (mismatches == 0) begin
            $display("multiframe_reassembly_crc_check_tb: PASS");
        end else begin
            $display("multiframe_reassembly_crc_check_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/mrcc_pkg.sv
src/mrcc_front.sv
src/mrcc_queue.sv
src/mrcc_back.sv
src/multiframe_reassembly_crc_check.sv
bench/multiframe_reassembly_crc_check_tb.sv
